/* src/ccc_pkg.sv */
// package: widths, register indexes, class codes and thresholds for the colour classifier
package ccc_pkg;

   localparam int SampleBits = 16;
   localparam int FracBits   = 12;
   localparam int ClearShift = 12;
   localparam int LevelBits  = FracBits + 2;
   localparam int RegBits    = 16;
   localparam int DenBits    = SampleBits + RegBits;
   localparam int NumBits    = SampleBits + ClearShift + FracBits;
   localparam int QuoBits    = FracBits + 2;
   localparam int Lanes      = 3;

   // register indexes
   localparam logic [2:0] RegAmbRed   = 3'd0;
   localparam logic [2:0] RegAmbGreen = 3'd1;
   localparam logic [2:0] RegAmbBlue  = 3'd2;
   localparam logic [2:0] RegWhtRed   = 3'd3;
   localparam logic [2:0] RegWhtGreen = 3'd4;
   localparam logic [2:0] RegWhtBlue  = 3'd5;
   localparam logic [2:0] RegClearRef = 3'd6;

   // colour class codes
   localparam logic [3:0] ClsUnknown   = 4'd0;
   localparam logic [3:0] ClsRed       = 4'd1;
   localparam logic [3:0] ClsGreen     = 4'd2;
   localparam logic [3:0] ClsBlue      = 4'd3;
   localparam logic [3:0] ClsYellow    = 4'd4;
   localparam logic [3:0] ClsPink      = 4'd5;
   localparam logic [3:0] ClsOrange    = 4'd6;
   localparam logic [3:0] ClsLightBlue = 4'd7;
   localparam logic [3:0] ClsWhite     = 4'd8;

   // thresholds rounded to the level grid
   localparam int ThOne   = 1 << FracBits;
   localparam int Th9_10  = ((9 << FracBits) + 5) / 10;
   localparam int Th3_2   = ((3 << FracBits) + 1) / 2;
   localparam int Th4_5   = ((4 << FracBits) + 2) / 5;
   localparam int Th2_5   = ((2 << FracBits) + 2) / 5;
   localparam int Th7_10  = ((7 << FracBits) + 5) / 10;
   localparam int Th3_10  = ((3 << FracBits) + 5) / 10;
   localparam int Th19_20 = ((19 << FracBits) + 10) / 20;
   localparam int Th13_10 = ((13 << FracBits) + 5) / 10;
   localparam int Th1_2   = ((1 << FracBits) + 1) / 2;

   // per-stage state carried along each lane's divider
   typedef struct packed {
      logic               zero;
      logic [NumBits-1:0] rem;
      logic [DenBits-1:0] den;
      logic [QuoBits-1:0] quo;
   } div_stage_type;

endpackage

/* src/calibrated_colour_classifier_core.sv */
// top level: calibration registers, three divider lanes, class merge and output register
//
// channel | direction | tdata fields (low bit first)
// req     | in        | red_count[15:0], green_count[31:16], blue_count[47:32]
// rsp     | out       | colour_class[3:0], red_level[17:4], green_level[31:18],
//         |           | blue_level[45:32], zeros to bit 47
// csr     | in        | index 0..6, 16-bit data
//
// one request per cycle while the pipeline advances; each request passes through the divider
// pipeline and the merge register. the pipeline advances whenever the output register is
// free or being drained, so a stall on rsp holds every stage. reset clears the
// valid bits and loads the calibration defaults.
module calibrated_colour_classifier_core
   import ccc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_count, green_count, blue_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // colour_class, red_level, green_level, blue_level
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int Depth = 3 + QuoBits;

   logic [SampleBits-1:0] amb_ff [Lanes];
   logic [SampleBits-1:0] wht_ff [Lanes];
   logic [RegBits-1:0]    clr_ff;

   // calibration register writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lanes; i++) begin
            amb_ff[i] <= '0;
            wht_ff[i] <= '1;
         end
         clr_ff <= RegBits'(4096);
      end else if (csr_valid) begin
         case (csr_index)
            RegAmbRed:   amb_ff[0] <= csr_data;
            RegAmbGreen: amb_ff[1] <= csr_data;
            RegAmbBlue:  amb_ff[2] <= csr_data;
            RegWhtRed:   wht_ff[0] <= csr_data;
            RegWhtGreen: wht_ff[1] <= csr_data;
            RegWhtBlue:  wht_ff[2] <= csr_data;
            RegClearRef: clr_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and valid tracking
   logic             adv;
   logic [Depth-1:0] vld_ff;
   logic             out_vld_ff;
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Depth-2:0], req_tvalid};
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   // lanes
   logic [LevelBits-1:0] lvl [Lanes];
   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      ccc_lane u_lane (
         .clock     (clock),
         .enable    (adv),
         .raw       (req_tdata[l*SampleBits +: SampleBits]),
         .ambient   (amb_ff[l]),
         .white     (wht_ff[l]),
         .clear_ref (clr_ff),
         .level     (lvl[l])
      );
   end

   // merge and output register
   logic [3:0]  cls;
   logic [47:0] out_ff;
   ccc_merge u_merge (.r(lvl[0]), .g(lvl[1]), .b(lvl[2]), .colour_class(cls));

   always_ff @(posedge clock) begin
      if (adv) out_ff <= {2'b00, lvl[2], lvl[1], lvl[0], cls};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule

/* src/ccc_lane.sv */
// lane: normalizes one colour channel with a pipelined restoring divider
module ccc_lane
   import ccc_pkg::*;
(
   input  logic                  clock,
   input  logic                  enable,
   input  logic [SampleBits-1:0] raw,
   input  logic [SampleBits-1:0] ambient,
   input  logic [SampleBits-1:0] white,
   input  logic [RegBits-1:0]    clear_ref,
   output logic [LevelBits-1:0]  level
);

   localparam int DcBits = SampleBits + RegBits;

   // stage 0: magnitudes and sign check
   logic                  s0_zero_ff, s0_zero_in;
   logic [SampleBits-1:0] s0_n_ff, s0_n_in, s0_d_ff, s0_d_in;
   logic [RegBits-1:0]    s0_c_ff;

   always_comb begin
      logic num_neg, den_neg;
      num_neg = raw < ambient;
      den_neg = white < ambient;
      s0_n_in = num_neg ? ambient - raw : raw - ambient;
      s0_d_in = den_neg ? ambient - white : white - ambient;
      s0_zero_in = (s0_n_in == '0) || (s0_d_in == '0) || (clear_ref == '0)
                   || (num_neg != den_neg);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_zero_ff <= s0_zero_in;
         s0_n_ff    <= s0_n_in;
         s0_d_ff    <= s0_d_in;
         s0_c_ff    <= clear_ref;
      end
   end

   // stage 1: divisor product
   logic                  s1_zero_ff;
   logic [SampleBits-1:0] s1_n_ff;
   logic [DcBits-1:0]     s1_dc_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_zero_ff <= s0_zero_ff;
         s1_n_ff    <= s0_n_ff;
         s1_dc_ff   <= DcBits'(s0_d_ff) * DcBits'(s0_c_ff);
      end
   end

   // stage 2: range check against twice the divisor
   div_stage_type s2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_ff.zero <= s1_zero_ff ||
            ((DcBits + 1)'({s1_n_ff, ClearShift'(0)}) > {s1_dc_ff, 1'b0});
         s2_ff.rem  <= {s1_n_ff, ClearShift'(0), FracBits'(0)};
         s2_ff.den  <= s1_dc_ff;
         s2_ff.quo  <= '0;
      end
   end

   // divider stages, one quotient bit each (quotient is at most 2 in level units)
   div_stage_type stg_ff [1:QuoBits];

   for (genvar k = 0; k < QuoBits; k++) begin : g_div
      localparam int Sh = QuoBits - 1 - k;
      div_stage_type cur, nx_in;
      if (k == 0) begin : g_first
         assign cur = s2_ff;
      end else begin : g_next
         assign cur = stg_ff[k];
      end
      always_comb begin
         logic [NumBits+QuoBits-1:0] trial;
         nx_in = cur;
         trial = (NumBits + QuoBits)'(cur.den) << Sh;
         if ((NumBits + QuoBits)'(cur.rem) >= trial) begin
            nx_in.rem    = cur.rem - NumBits'(trial);
            nx_in.quo[Sh] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) stg_ff[k+1] <= nx_in;
      end
   end

   assign level = stg_ff[QuoBits].zero ? '0 : LevelBits'(stg_ff[QuoBits].quo);

endmodule

/* src/ccc_merge.sv */
// merge: priority chain of threshold tests on the three lane levels
module ccc_merge
   import ccc_pkg::*;
(
   input  logic [LevelBits-1:0] r,
   input  logic [LevelBits-1:0] g,
   input  logic [LevelBits-1:0] b,
   output logic [3:0]           colour_class
);

   localparam int W = LevelBits + 2;

   always_comb begin
      logic signed [W-1:0] rs, gs, bs;
      rs = $signed({2'b00, r});
      gs = $signed({2'b00, g});
      bs = $signed({2'b00, b});
      if (rs > W'(Th9_10) && gs > W'(Th9_10) && bs > W'(Th9_10))
         colour_class = ClsWhite;
      else if (rs > W'(Th3_2) && rs - gs > W'(Th4_5) && rs - bs > W'(Th4_5))
         colour_class = ClsRed;
      else if (gs - rs > W'(Th2_5) && gs > W'(ThOne) && gs - bs > W'(Th2_5))
         colour_class = ClsGreen;
      else if (bs - rs > W'(Th7_10) && bs - gs > W'(Th3_10) && bs > W'(Th7_10))
         colour_class = ClsBlue;
      else if (rs > W'(ThOne) && gs > W'(Th4_5) && bs < W'(Th4_5))
         colour_class = ClsYellow;
      else if (rs > W'(Th19_20) && gs > W'(Th4_5) && gs < W'(Th9_10) &&
               bs > W'(Th4_5) && bs < W'(Th19_20))
         colour_class = ClsPink;
      else if (rs > W'(Th13_10) && gs > W'(Th1_2) && bs > W'(Th1_2))
         colour_class = ClsOrange;
      else if (rs < W'(Th7_10) && gs > W'(ThOne) && bs > W'(ThOne))
         colour_class = ClsLightBlue;
      else
         colour_class = ClsUnknown;
   end

endmodule
